>>> rtl/erfd_pkg.sv
// Package for the escaped response frame decoder.
// Holds the beat types, status and kind codes, constants and the CRC-16 step.
// No dependencies.
package erfd_pkg;

    localparam int WORD_LIMIT = 31;

    localparam logic [7:0]  ESC_BYTE         = 8'hC5;
    localparam logic [7:0]  SYNC_SUB         = 8'hB5;
    localparam logic [7:0]  RESP_OK          = 8'h01;
    localparam logic [7:0]  LEN_MAX          = 8'hFF;
    localparam logic [15:0] CRC_POLY         = 16'h1021;
    localparam logic [4:0]  WORD_COUNT_RESET = 5'd1;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_BAD_CODE   = 2'd1,
        ST_BAD_LENGTH = 2'd2,
        ST_BAD_CRC    = 2'd3
    } status_t;

    typedef enum logic {
        KIND_WORD   = 1'b0,
        KIND_STATUS = 1'b1
    } kind_t;

    typedef struct packed {
        logic [7:0] raw_byte;
        logic       end_of_frame;
    } erfd_in_t;

    typedef struct packed {
        kind_t       kind;
        logic [31:0] word_value;
        logic [4:0]  word_index;
        status_t     status;
        logic        last;
    } erfd_out_t;

    // Up to two results produced by one processed byte, head result first.
    typedef struct packed {
        logic [1:0] count;
        erfd_out_t  res0;
        erfd_out_t  res1;
    } erfd_push_t;

    typedef struct packed {
        logic        esc;
        logic [7:0]  len;
        logic [15:0] crc;
        logic [23:0] wasm;
        logic [15:0] rcrc;
        logic        cbad;
    } erfd_state_t;

    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

    function automatic logic [4:0] words_expected(input logic [4:0] wc);
        logic [6:0] limit;
        limit = 7'(WORD_LIMIT);
        if ({2'b00, wc} > limit) begin
            return limit[4:0];
        end
        return wc;
    endfunction

endpackage

>>> rtl/erfd_decode.sv
// Per-byte unstuffing, word assembly, CRC and frame status logic with its state.
// Depends on erfd_pkg.
module erfd_decode
    import erfd_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       fire,
    input  erfd_in_t   beat,
    input  logic [4:0] word_count,
    output erfd_push_t push
);

    erfd_state_t st_reg, st_next;
    logic        have;
    logic        emit;
    logic [7:0]  dbyte;
    logic [7:0]  rel;
    logic [5:0]  k;
    logic [4:0]  nwords;
    logic [7:0]  exp_len;
    status_t     stat;
    erfd_out_t   res_word, res_stat;

    assign nwords  = words_expected(word_count);
    assign exp_len = 8'({nwords, 2'b00}) + 8'd4;
    assign rel     = st_reg.len - 8'd2;
    assign k       = rel[7:2];

    always_comb begin
        st_next = st_reg;
        have    = 1'b0;
        emit    = 1'b0;
        dbyte   = beat.raw_byte;
        stat    = ST_OK;

        if (st_reg.len == 8'd0 && !st_reg.esc) begin
            have = 1'b1;
        end else if (st_reg.esc) begin
            dbyte       = (beat.raw_byte == 8'd0) ? SYNC_SUB : ESC_BYTE;
            st_next.esc = 1'b0;
            have        = 1'b1;
        end else if (beat.raw_byte == ESC_BYTE) begin
            st_next.esc = 1'b1;
        end else begin
            have = 1'b1;
        end

        if (have) begin
            if (st_reg.len == 8'd1 && dbyte != RESP_OK) begin
                st_next.cbad = 1'b1;
            end
            if (st_reg.len >= 8'd2) begin
                if (k < {1'b0, nwords}) begin
                    if (rel[1:0] == 2'd3) begin
                        emit         = 1'b1;
                        st_next.wasm = '0;
                    end else begin
                        st_next.wasm = {st_reg.wasm[15:0], dbyte};
                    end
                end
                st_next.crc = crc16_byte(st_reg.crc, st_reg.rcrc[15:8]);
            end
            st_next.rcrc = {st_reg.rcrc[7:0], dbyte};
            if (st_reg.len < LEN_MAX) begin
                st_next.len = st_reg.len + 8'd1;
            end
        end

        // Status is judged on the state after this byte.
        if (st_next.len < 8'd2) begin
            stat = ST_BAD_LENGTH;
        end else if (st_next.cbad) begin
            stat = ST_BAD_CODE;
        end else if (st_next.esc || st_next.len != exp_len) begin
            stat = ST_BAD_LENGTH;
        end else if (st_next.crc != st_next.rcrc) begin
            stat = ST_BAD_CRC;
        end

        if (beat.end_of_frame) begin
            st_next = '0;
        end
    end

    always_comb begin
        res_word.kind       = KIND_WORD;
        res_word.word_value = {st_reg.wasm, dbyte};
        res_word.word_index = k[4:0];
        res_word.status     = ST_OK;
        res_word.last       = 1'b0;

        res_stat.kind       = KIND_STATUS;
        res_stat.word_value = '0;
        res_stat.word_index = '0;
        res_stat.status     = stat;
        res_stat.last       = 1'b1;

        push.count = fire ? (2'(emit) + 2'(beat.end_of_frame)) : 2'd0;
        push.res0  = emit ? res_word : res_stat;
        push.res1  = res_stat;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= '0;
        end else if (fire) begin
            st_reg <= st_next;
        end
    end

`ifndef SYNTH
    a_pair_order: assert property (@(posedge aclk) disable iff (!aresetn)
        push.count == 2'd2 |-> push.res0.kind == KIND_WORD && push.res1.kind == KIND_STATUS)
        else $error("two results must be a word followed by a status");

    a_frame_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && beat.end_of_frame |=> st_reg == '0)
        else $error("frame state not cleared after end of frame");
`endif

endmodule

>>> rtl/erfd_out_queue.sv
// Two-entry result buffer that drives the result channel.
// Depends on erfd_pkg.
module erfd_out_queue
    import erfd_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  erfd_push_t push,
    output logic       space,
    output logic       m_valid,
    input  logic       m_ready,
    output erfd_out_t  m_data
);

    logic [1:0] count_reg, count_next;
    erfd_out_t  ent0_reg, ent0_next;
    erfd_out_t  ent1_reg, ent1_next;
    logic       pop;

    assign m_valid = (count_reg != 2'd0);
    assign m_data  = ent0_reg;
    assign pop     = m_valid && m_ready;
    // A push is only allowed when the buffer will be empty after this cycle's pop.
    assign space   = (count_reg == 2'd0) || (count_reg == 2'd1 && m_ready);

    always_comb begin
        count_next = count_reg - 2'(pop) + push.count;
        ent0_next  = ent0_reg;
        ent1_next  = ent1_reg;
        if (push.count != 2'd0) begin
            ent0_next = push.res0;
            ent1_next = push.res1;
        end else if (pop) begin
            ent0_next = ent1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= 2'd0;
        end else begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        ent0_reg <= ent0_next;
        ent1_reg <= ent1_next;
    end

`ifndef SYNTH
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg != 2'd3)
        else $error("result buffer overflow");

    a_push_into_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        push.count != 2'd0 |-> count_reg == 2'd0 || (count_reg == 2'd1 && pop))
        else $error("push while the buffer still holds results");
`endif

endmodule

>>> rtl/escaped_response_frame_decoder_unit.sv
// Escaped response frame decoder top level; depends on erfd_pkg, erfd_decode, erfd_out_queue.
// A beat in the input register is processed once the result buffer can take both results
// it might produce, which the buffer registers and offers. Throughput: one input beat per
// cycle while results drain. An end-of-frame beat that also completes a word yields two
// beats and holds the input until the result buffer drains. Reset (aresetn, synchronous,
// active low) empties all stages, clears the frame state and sets word_count to 1.
module escaped_response_frame_decoder_unit
    import erfd_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,

    input  logic       s_valid,
    output logic       s_ready,
    input  erfd_in_t   s_data,

    output logic       m_valid,
    input  logic       m_ready,
    output erfd_out_t  m_data,

    input  logic       cfg_wr_en,
    input  logic [4:0] cfg_wr_data
);

    // The input register holds one beat. It is processed as soon as the result
    // buffer can take both results it might produce, so a fresh beat can be
    // taken in the same cycle the held one moves on.
    logic       in_vld_reg, in_vld_next;
    erfd_in_t   in_reg;
    logic [4:0] wc_reg;
    logic       fire;
    logic       space;
    erfd_push_t push;

    assign fire    = in_vld_reg && space;
    assign s_ready = !in_vld_reg || fire;

    always_comb begin
        in_vld_next = in_vld_reg;
        if (s_valid && s_ready) begin
            in_vld_next = 1'b1;
        end else if (fire) begin
            in_vld_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
            wc_reg     <= WORD_COUNT_RESET;
        end else begin
            in_vld_reg <= in_vld_next;
            if (cfg_wr_en) begin
                wc_reg <= cfg_wr_data;
            end
        end
    end

    // The payload register needs no reset; it is qualified by in_vld_reg.
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg <= s_data;
        end
    end

    // Unstuffing, word assembly, CRC and the frame verdict for the held beat.
    erfd_decode u_decode (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .fire       (fire),
        .beat       (in_reg),
        .word_count (wc_reg),
        .push       (push)
    );

    // Results wait here until the downstream side takes them, one beat at a time.
    erfd_out_queue u_out_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .space   (space),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

`ifndef SYNTH
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !in_vld_reg |-> s_ready)
        else $error("input stage empty but not ready");
`endif

endmodule

>>> test/escaped_response_frame_decoder_unit_tb.sv
// Self-checking testbench for the escaped response frame decoder unit.
// Drives stuffed reply frames, predicts data word and status beats, and checks every output beat.
// Depends on erfd_pkg and escaped_response_frame_decoder_unit.
module escaped_response_frame_decoder_unit_tb;
    import erfd_pkg::*;

    // The run is cut off after this many clock cycles. A correct run needs far fewer.
    localparam int LIMIT_CYCLES = 300000;

    // Ways in which a generated frame can be damaged before it goes on the line.
    typedef enum int {
        FLAW_NONE,
        FLAW_DATA,
        FLAW_CODE,
        FLAW_CRC,
        FLAW_SHORT,
        FLAW_LONG,
        FLAW_DANGLE
    } frame_flaw_t;

    logic       aclk = 1'b0;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    erfd_in_t   s_data;
    logic       m_valid;
    logic       m_ready;
    erfd_out_t  m_data;
    logic       cfg_wr_en;
    logic [4:0] cfg_wr_data;

    // Output beats that the decoder still owes, oldest first.
    erfd_out_t decoded_beats_due[$];

    // Decoded bytes of the frame under construction and the stuffed line bytes built from them.
    logic [7:0] frame_bytes[$];
    logic [7:0] line_bytes[$];

    int bytes_sent = 0;
    int mismatch_count = 0;
    int rx_hold_cycles = 0;
    bit quiet = 1'b0;

    // Shadow copy of the decoder's frame state and its word count register.
    logic [4:0]  word_count_reg;
    logic        esc_seen;
    logic [7:0]  dec_count;
    logic [15:0] crc_run;
    logic [23:0] word_bytes;
    logic [15:0] crc_tail;
    logic        code_wrong;

    escaped_response_frame_decoder_unit i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // One step of the CRC-16 with polynomial 0x1021, MSB first, no reflection.
    function automatic logic [15:0] crc_ccitt_step(input logic [15:0] acc, input logic [7:0] b);
        logic [15:0] c;
        c = acc ^ {b, 8'h00};
        repeat (8) begin
            c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

    // Byte values are biased toward the escape byte, its substitute and the extremes.
    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 7))
            0: return ESC_BYTE;
            1: return SYNC_SUB;
            2: return 8'h00;
            3: return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic string beat_text(input erfd_out_t b);
        return $sformatf("kind %0d value %h index %0d status %0d last %0d",
                         b.kind, b.word_value, b.word_index, b.status, b.last);
    endfunction

    task automatic clear_frame_model();
        esc_seen   = 1'b0;
        dec_count  = '0;
        crc_run    = '0;
        word_bytes = '0;
        crc_tail   = '0;
        code_wrong = 1'b0;
    endtask

    // Advances the shadow state by one accepted line byte and queues the beats it causes.
    // A completed word is queued ahead of the status beat when both fall on one byte.
    task automatic decode_line_byte(input logic [7:0] raw, input logic eof);
        erfd_out_t beat;
        logic [7:0] d;
        logic       have;
        int         rel;
        int         limit;
        limit = (word_count_reg > WORD_LIMIT) ? WORD_LIMIT : int'(word_count_reg);
        have = 1'b0;
        d = raw;
        if (dec_count == 0 && !esc_seen) begin
            // The sync byte is never unstuffed.
            have = 1'b1;
        end else if (esc_seen) begin
            d = (raw == 8'h00) ? SYNC_SUB : ESC_BYTE;
            esc_seen = 1'b0;
            have = 1'b1;
        end else if (raw == ESC_BYTE) begin
            esc_seen = 1'b1;
        end else begin
            have = 1'b1;
        end

        if (have) begin
            if (dec_count == 1 && d != RESP_OK) begin
                code_wrong = 1'b1;
            end
            if (dec_count >= 2) begin
                rel = int'(dec_count) - 2;
                if (rel / 4 < limit) begin
                    if (rel % 4 == 3) begin
                        beat = '0;
                        beat.kind = KIND_WORD;
                        beat.word_value = {word_bytes, d};
                        beat.word_index = 5'(rel / 4);
                        beat.status = ST_OK;
                        beat.last = 1'b0;
                        decoded_beats_due.insert(decoded_beats_due.size(), beat);
                        word_bytes = '0;
                    end else begin
                        word_bytes = {word_bytes[15:0], d};
                    end
                end
                // The CRC trails by two bytes, so that the last two are the received CRC.
                crc_run = crc_ccitt_step(crc_run, crc_tail[15:8]);
            end
            crc_tail = {crc_tail[7:0], d};
            if (dec_count != LEN_MAX) begin
                dec_count++;
            end
        end

        if (eof) begin
            beat = '0;
            beat.kind = KIND_STATUS;
            beat.last = 1'b1;
            if (dec_count < 2) begin
                beat.status = ST_BAD_LENGTH;
            end else if (code_wrong) begin
                beat.status = ST_BAD_CODE;
            end else if (esc_seen || int'(dec_count) != 4 * limit + 4) begin
                beat.status = ST_BAD_LENGTH;
            end else if (crc_run != crc_tail) begin
                beat.status = ST_BAD_CRC;
            end else begin
                beat.status = ST_OK;
            end
            decoded_beats_due.insert(decoded_beats_due.size(), beat);
            clear_frame_model();
        end
    endtask

    // Offers one line byte and returns at the edge that accepts it. Valid stays high on
    // return, so back-to-back beats never drop it; a random gap lowers it first.
    task automatic send_raw_byte(input logic [7:0] raw, input logic eof);
        int gap;
        if (!quiet && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 9);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= '{raw_byte: raw, end_of_frame: eof};
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        decode_line_byte(raw, eof);
        bytes_sent++;
    endtask

    task automatic send_line(input logic eof_last);
        foreach (line_bytes[i]) begin
            send_raw_byte(line_bytes[i], eof_last && i == line_bytes.size() - 1);
        end
        line_bytes.delete();
    endtask

    // Appends the big-endian CRC over all decoded bytes collected so far.
    task automatic add_crc();
        logic [15:0] crc;
        crc = '0;
        foreach (frame_bytes[i]) begin
            crc = crc_ccitt_step(crc, frame_bytes[i]);
        end
        frame_bytes.insert(frame_bytes.size(), crc[15:8]);
        frame_bytes.insert(frame_bytes.size(), crc[7:0]);
    endtask

    // Stuffs decoded bytes from index first onward into line bytes. A literal escape byte
    // is followed by any nonzero byte; 0xB5 may go out either raw or as escape plus zero.
    task automatic stuff_frame(input int first, input bit b5_always);
        logic [7:0] d;
        for (int i = first; i < frame_bytes.size(); i++) begin
            d = frame_bytes[i];
            if (i == 0) begin
                line_bytes.insert(line_bytes.size(), d);
            end else if (d == ESC_BYTE) begin
                line_bytes.insert(line_bytes.size(), ESC_BYTE);
                line_bytes.insert(line_bytes.size(), 8'($urandom_range(1, 255)));
            end else if (d == SYNC_SUB && (b5_always || $urandom_range(0, 1) == 1)) begin
                line_bytes.insert(line_bytes.size(), ESC_BYTE);
                line_bytes.insert(line_bytes.size(), 8'h00);
            end else begin
                line_bytes.insert(line_bytes.size(), d);
            end
        end
    endtask

    task automatic send_frame(input int nwords, input frame_flaw_t flaw, input int extra);
        logic [7:0] code;
        logic [7:0] pad;
        int         idx;
        int         cut;
        frame_bytes.delete();
        frame_bytes.insert(frame_bytes.size(), pick_byte());
        code = pick_byte();
        if (code == RESP_OK) begin
            code = 8'h02;
        end
        frame_bytes.insert(frame_bytes.size(), flaw == FLAW_CODE ? code : RESP_OK);
        repeat (4 * nwords) frame_bytes.insert(frame_bytes.size(), pick_byte());
        add_crc();
        if (flaw == FLAW_DATA) begin
            // Damage any covered byte but the response code.
            idx = $urandom_range(0, frame_bytes.size() - 3);
            if (idx == 1) begin
                idx = 0;
            end
            frame_bytes[idx] ^= 8'(1 << $urandom_range(0, 7));
        end else if (flaw == FLAW_CRC) begin
            idx = frame_bytes.size() - 1 - $urandom_range(0, 1);
            frame_bytes[idx] ^= 8'(1 << $urandom_range(0, 7));
        end
        stuff_frame(0, 1'b0);
        case (flaw)
            FLAW_SHORT: begin
                cut = $urandom_range(1, 3);
                while (cut > 0 && line_bytes.size() > 1) begin
                    void'(line_bytes.pop_back());
                    cut--;
                end
            end
            FLAW_LONG: begin
                // Each pad step decodes to exactly one excess byte.
                repeat (extra) begin
                    pad = pick_byte();
                    line_bytes.insert(line_bytes.size(), pad);
                    if (pad == ESC_BYTE) begin
                        line_bytes.insert(line_bytes.size(), 8'($urandom_range(0, 255)));
                    end
                end
            end
            FLAW_DANGLE: begin
                line_bytes.insert(line_bytes.size(), ESC_BYTE);
            end
            default: begin
            end
        endcase
        send_line(1'b1);
    endtask

    // Unstructured bytes with frame ends scattered among them, closed by a frame end.
    task automatic send_noise(input int count);
        repeat (count) send_raw_byte(pick_byte(), $urandom_range(0, 7) == 0);
        send_raw_byte(pick_byte(), 1'b1);
    endtask

    task automatic send_random_frame(input int nwords);
        int pick;
        pick = $urandom_range(0, 19);
        if (pick < 12) begin
            send_frame(nwords, FLAW_NONE, 0);
        end else begin
            case (pick)
                12: send_frame(nwords, FLAW_DATA, 0);
                13: send_frame(nwords, FLAW_CODE, 0);
                14: send_frame(nwords, FLAW_CRC, 0);
                15: send_frame(nwords, FLAW_SHORT, 0);
                16: send_frame(nwords, FLAW_LONG, $urandom_range(1, 6));
                17: send_frame(nwords, FLAW_DANGLE, 0);
                default: send_noise($urandom_range(1, 12));
            endcase
        end
    endtask

    // Drops valid and waits until every owed beat has arrived, then lets the input stage
    // empty out, since a byte that completes nothing leaves no beat to wait for.
    task automatic settle();
        s_valid <= 1'b0;
        while (decoded_beats_due.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // Must be entered at a clock edge while the decoder is idle.
    task automatic write_word_count(input logic [4:0] count);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= count;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        word_count_reg = count;
    endtask

    task automatic run_phase(input logic [4:0] count, input int quota);
        int stop_at;
        settle();
        write_word_count(count);
        stop_at = bytes_sent + quota;
        while (bytes_sent < stop_at) begin
            send_random_frame(count);
        end
    endtask

    // A good frame at the reset word count whose sync byte is the escape byte and whose
    // data word holds both stuffed values, the zero byte and the all-ones byte.
    task automatic test_escaped_frame();
        frame_bytes = '{ESC_BYTE, RESP_OK, SYNC_SUB, ESC_BYTE, 8'h00, 8'hFF};
        add_crc();
        stuff_frame(0, 1'b1);
        send_line(1'b1);
    endtask

    // A lone sync byte, and a frame that stops right after an escape byte.
    task automatic test_short_frames();
        line_bytes = '{8'h00};
        send_line(1'b1);
        line_bytes = '{8'h7E, RESP_OK, ESC_BYTE};
        send_line(1'b1);
    endtask

    // With no data words a frame is sync, code and CRC. A wrong code must be reported
    // even though the CRC covers it correctly.
    task automatic test_zero_words_and_bad_code();
        settle();
        write_word_count(5'd0);
        frame_bytes = '{8'h3C, 8'h80};
        add_crc();
        stuff_frame(0, 1'b0);
        send_line(1'b1);
        frame_bytes = '{8'hA5, RESP_OK};
        add_crc();
        stuff_frame(0, 1'b0);
        send_line(1'b1);
    endtask

    task automatic test_bad_crc();
        frame_bytes = '{8'h5A, RESP_OK};
        add_crc();
        frame_bytes[3] ^= 8'h01;
        stuff_frame(0, 1'b0);
        send_line(1'b1);
    endtask

    // The word count changes between the code byte and the first data byte, so the rest
    // of the frame must be judged against the new count.
    task automatic test_config_mid_frame();
        frame_bytes = '{8'h69, RESP_OK};
        stuff_frame(0, 1'b0);
        send_line(1'b0);
        settle();
        write_word_count(5'd1);
        frame_bytes.insert(frame_bytes.size(), 8'h12);
        frame_bytes.insert(frame_bytes.size(), 8'h34);
        frame_bytes.insert(frame_bytes.size(), SYNC_SUB);
        frame_bytes.insert(frame_bytes.size(), 8'h78);
        add_crc();
        stuff_frame(2, 1'b0);
        send_line(1'b1);
    endtask

    task automatic test_random_traffic();
        run_phase(5'd1, 50);
        run_phase(5'd2, 50);
        run_phase(5'd0, 40);
        run_phase(5'd4, 50);
        run_phase(5'($urandom_range(1, 6)), 50);
    endtask

    // The receiver stops for a long stretch while full frames keep coming, so the
    // decoder's output side fills up and it has to hold off the input.
    task automatic test_backpressure();
        settle();
        write_word_count(5'd3);
        rx_hold_cycles = 300;
        repeat (5) send_frame(3, FLAW_NONE, 0);
    endtask

    // The largest word count, once well formed and once padded past the point where the
    // decoded length saturates.
    task automatic test_overlong_frame();
        settle();
        write_word_count(5'd31);
        send_frame(31, FLAW_NONE, 0);
        send_frame(31, FLAW_LONG, 130);
    endtask

    // The last stretch runs at full rate on both sides.
    task automatic test_quiet_tail();
        quiet = 1'b1;
        run_phase(5'd1, 80);
    endtask

    // Receiver side: random stalls, or a long hold when one is asked for.
    initial begin : rx_pacing
        int stall;
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (rx_hold_cycles > 0) begin
                stall = rx_hold_cycles;
                rx_hold_cycles = 0;
                m_ready <= 1'b0;
                repeat (stall - 1) @(posedge aclk);
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                stall = $urandom_range(1, 9);
                m_ready <= 1'b0;
                repeat (stall - 1) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Every accepted output beat is matched against the oldest owed beat.
    always @(posedge aclk) begin : beat_check
        erfd_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (decoded_beats_due.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10) begin
                    $display("unexpected output beat: %s", beat_text(m_data));
                end
            end else begin
                want = decoded_beats_due.pop_front();
                if (m_data.kind !== want.kind || m_data.word_value !== want.word_value ||
                    m_data.word_index !== want.word_index || m_data.status !== want.status ||
                    m_data.last !== want.last) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("output beat mismatch: expected %s", beat_text(want));
                        $display("                      actual   %s", beat_text(m_data));
                    end
                end
            end
        end
    end

    initial begin
        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_data <= '0;
        cfg_wr_en <= 1'b0;
        cfg_wr_data <= '0;
        word_count_reg = WORD_COUNT_RESET;
        clear_frame_model();
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        test_escaped_frame();
        test_short_frames();
        test_zero_words_and_bad_code();
        test_bad_crc();
        test_config_mid_frame();
        test_random_traffic();
        test_backpressure();
        test_overlong_frame();
        test_quiet_tail();

        // Wait for the last owed beat, then watch a while longer for stray beats.
        settle();
        repeat (16) @(posedge aclk);
        if (mismatch_count == 0 && decoded_beats_due.size() == 0) begin
            $display("escaped_response_frame_decoder_unit_tb: PASS");
        end else begin
            $display("escaped_response_frame_decoder_unit_tb: FAIL");
        end
        $finish;
    end

    initial begin
        #(LIMIT_CYCLES * 8);
        $display("escaped_response_frame_decoder_unit_tb: FAIL");
        $finish;
    end

endmodule
